// File: rtl/bmmd_pkg.sv
// ----------------------------------------------------------------------------
// Bank-mapped memory decoder package
// Shared types and constants for the CPU memory-map decoder.
// ----------------------------------------------------------------------------
package bmmd_pkg;

    // Field widths of one input beat, one result beat and the kept state.
    localparam int CMD_W    = 4;
    localparam int ADDR_W   = 16;
    localparam int DATA_W   = 8;
    localparam int LINE_W   = 9;
    localparam int REGION_W = 3;
    localparam int VB_W     = 2;
    localparam int PAGE_W   = 3;

    // Default machine variant after reset.
    localparam logic DEFAULT_VARIANT = 1'b0;

    // Bus commands.
    typedef enum logic [CMD_W-1:0] {
        CMD_READ    = 4'd0,
        CMD_WRITE   = 4'd1,
        CMD_FETCH   = 4'd2,
        CMD_IOWR    = 4'd3,
        CMD_VSEL    = 4'd4,
        CMD_LINE    = 4'd5,
        CMD_HBLANK  = 4'd6,
        CMD_IPL     = 4'd7,
        CMD_SPECIAL = 4'd8
    } t_cmd;

    // Target regions.
    typedef enum logic [REGION_W-1:0] {
        REG_EMPTY = 3'd0,
        REG_ROM   = 3'd1,
        REG_RAM   = 3'd2,
        REG_GVRAM = 3'd3,
        REG_TVRAM = 3'd4
    } t_region;

    // Vertical blank port drive codes.
    typedef enum logic [VB_W-1:0] {
        VB_NONE = 2'd0,
        VB_HIGH = 2'd1,
        VB_LOW  = 2'd2
    } t_vb;

    // Machine variants.
    localparam logic VARIANT_FOUR_PAGE = 1'b0;
    localparam logic VARIANT_TWO_PAGE  = 1'b1;

    // Map constants.
    localparam logic [ADDR_W-1:0] ROM_END    = 16'h0800;
    localparam logic [ADDR_W-1:0] RAM_HI     = 16'h8000;
    localparam logic [ADDR_W-1:0] PAGE_SIZE  = 16'h4000;
    localparam logic [ADDR_W-1:0] V0_GVRAM   = 16'hc000;
    localparam logic [ADDR_W-1:0] HI_TVRAM   = 16'hd000;
    localparam logic [ADDR_W-1:0] HI_GVRAM   = 16'he000;
    localparam logic [ADDR_W-1:0] LO_TVRAM   = 16'h5000;
    localparam logic [ADDR_W-1:0] LO_GVRAM   = 16'h6000;
    localparam logic [DATA_W-1:0] VSEL_GRAPH = 8'h80;
    localparam logic [DATA_W-1:0] VSEL_TEXT  = 8'hc0;
    localparam logic [DATA_W-1:0] PORT_PAGE  = 8'hf7;
    localparam logic [DATA_W-1:0] PORT_LO    = 8'hf4;
    localparam logic [LINE_W-1:0] LINE_TOP   = 9'd0;
    localparam logic [LINE_W-1:0] LINE_VBL   = 9'd200;

    // Kept decoder state.
    typedef struct packed {
        logic              boot_mode;
        logic [DATA_W-1:0] video_select;
        logic [PAGE_W-1:0] video_page;
        logic              in_hblank;
    } t_state;

    // One input beat.
    typedef struct packed {
        logic [CMD_W-1:0]  command;
        logic [ADDR_W-1:0] address;
        logic [DATA_W-1:0] data;
        logic [LINE_W-1:0] line_number;
    } t_item;

    // One result beat.
    typedef struct packed {
        logic [REGION_W-1:0] region;
        logic [ADDR_W-1:0]   phys_offset;
        logic                wait_state;
        logic                busreq_assert;
        logic                busreq_release;
        logic [VB_W-1:0]     vblank_drive;
    } t_result;

endpackage

// File: rtl/bmmd_in_if.sv
// ----------------------------------------------------------------------------
// Decoder input channel
// Valid/ready channel carrying one bus access or event per beat.
// ----------------------------------------------------------------------------
interface bmmd_in_if;
    logic                        valid;
    logic                        ready;
    logic [bmmd_pkg::CMD_W-1:0]  command;
    logic [bmmd_pkg::ADDR_W-1:0] address;
    logic [bmmd_pkg::DATA_W-1:0] data;
    logic [bmmd_pkg::LINE_W-1:0] line_number;

    modport source (output valid, command, address, data, line_number, input ready);
    modport sink   (input valid, command, address, data, line_number, output ready);
endinterface

// File: rtl/bmmd_out_if.sv
// ----------------------------------------------------------------------------
// Decoder result channel
// Valid/ready channel carrying one decode result per beat.
// ----------------------------------------------------------------------------
interface bmmd_out_if;
    logic                          valid;
    logic                          ready;
    logic [bmmd_pkg::REGION_W-1:0] region;
    logic [bmmd_pkg::ADDR_W-1:0]   phys_offset;
    logic                          wait_state;
    logic                          busreq_assert;
    logic                          busreq_release;
    logic [bmmd_pkg::VB_W-1:0]     vblank_drive;

    modport source (output valid, region, phys_offset, wait_state, busreq_assert,
                    busreq_release, vblank_drive, input ready);
    modport sink   (input valid, region, phys_offset, wait_state, busreq_assert,
                    busreq_release, vblank_drive, output ready);
endinterface

// File: rtl/bmmd_decode.sv
// ----------------------------------------------------------------------------
// Decoder core logic
// Maps one beat to its result and computes the next kept state.
// ----------------------------------------------------------------------------
module bmmd_decode (
    input  logic             i_variant,
    input  bmmd_pkg::t_state i_state,
    input  bmmd_pkg::t_item  i_item,
    output bmmd_pkg::t_result o_result,
    output bmmd_pkg::t_state o_state
);

    logic [bmmd_pkg::ADDR_W-1:0]   a;
    logic                          is_wr;
    logic                          in_rom;
    logic [bmmd_pkg::REGION_W-1:0] map_reg;
    logic [bmmd_pkg::ADDR_W-1:0]   map_off;
    logic [1:0]                    pg;
    logic [bmmd_pkg::ADDR_W-1:0]   gb;
    logic [bmmd_pkg::DATA_W-1:0]   port;

    assign a      = i_item.address;
    assign is_wr  = (i_item.command == bmmd_pkg::CMD_WRITE);
    assign in_rom = (a < bmmd_pkg::ROM_END);
    assign pg     = i_state.video_page[1:0];
    assign gb     = i_state.video_page[0] ? bmmd_pkg::PAGE_SIZE : '0;
    assign port   = a[bmmd_pkg::DATA_W-1:0];

    // Address map: boot/RAM base map, then the video overlay of the variant.
    always_comb begin
        if (i_state.boot_mode) begin
            if (in_rom) begin
                map_reg = is_wr ? bmmd_pkg::REG_EMPTY : bmmd_pkg::REG_ROM;
                map_off = is_wr ? '0 : a;
            end else if (a < bmmd_pkg::RAM_HI) begin
                map_reg = bmmd_pkg::REG_EMPTY;
                map_off = '0;
            end else begin
                map_reg = bmmd_pkg::REG_RAM;
                map_off = a - bmmd_pkg::RAM_HI;
            end
        end else begin
            map_reg = bmmd_pkg::REG_RAM;
            map_off = a;
        end

        if (i_variant == bmmd_pkg::VARIANT_FOUR_PAGE) begin
            if (i_state.video_select == bmmd_pkg::VSEL_GRAPH && a >= bmmd_pkg::V0_GVRAM) begin
                if (pg != 2'd0) begin
                    map_reg = bmmd_pkg::REG_GVRAM;
                    map_off = {pg, 14'd0} + (a - bmmd_pkg::V0_GVRAM);
                end else begin
                    map_reg = bmmd_pkg::REG_EMPTY;
                    map_off = '0;
                end
            end else if (i_state.video_select == bmmd_pkg::VSEL_TEXT
                         && a >= bmmd_pkg::HI_TVRAM && a < bmmd_pkg::HI_GVRAM) begin
                map_reg = bmmd_pkg::REG_TVRAM;
                map_off = a - bmmd_pkg::HI_TVRAM;
            end
        end else begin
            if (i_state.video_select == bmmd_pkg::VSEL_GRAPH) begin
                if (a >= bmmd_pkg::HI_TVRAM && a < bmmd_pkg::HI_GVRAM) begin
                    map_reg = bmmd_pkg::REG_TVRAM;
                    map_off = a - bmmd_pkg::HI_TVRAM;
                end else if (a >= bmmd_pkg::HI_GVRAM) begin
                    map_reg = bmmd_pkg::REG_GVRAM;
                    map_off = gb + (a - bmmd_pkg::HI_GVRAM);
                end
            end else if (i_state.video_select == bmmd_pkg::VSEL_TEXT) begin
                if (a >= bmmd_pkg::LO_TVRAM && a < bmmd_pkg::LO_GVRAM) begin
                    map_reg = bmmd_pkg::REG_TVRAM;
                    map_off = a - bmmd_pkg::LO_TVRAM;
                end else if (a >= bmmd_pkg::LO_GVRAM && a < bmmd_pkg::RAM_HI) begin
                    map_reg = bmmd_pkg::REG_GVRAM;
                    map_off = gb + (a - bmmd_pkg::LO_GVRAM);
                end
            end
        end
    end

    // Command dispatch: result fields and state updates.
    always_comb begin
        o_result = '0;
        o_state  = i_state;
        case (bmmd_pkg::t_cmd'(i_item.command))
            bmmd_pkg::CMD_READ, bmmd_pkg::CMD_WRITE: begin
                o_result.region        = map_reg;
                o_result.phys_offset   = map_off;
                o_result.busreq_assert = !i_state.in_hblank
                    && (map_reg == bmmd_pkg::REG_GVRAM || map_reg == bmmd_pkg::REG_TVRAM);
            end
            bmmd_pkg::CMD_FETCH: begin
                o_result.region      = map_reg;
                o_result.phys_offset = map_off;
                o_result.wait_state  = i_state.boot_mode && in_rom;
            end
            bmmd_pkg::CMD_IOWR: begin
                if (i_variant == bmmd_pkg::VARIANT_FOUR_PAGE) begin
                    if (port == bmmd_pkg::PORT_PAGE) begin
                        o_state.video_page = {1'b0, i_item.data[1:0]};
                    end
                end else if (port >= bmmd_pkg::PORT_LO && port <= bmmd_pkg::PORT_PAGE) begin
                    o_state.video_page = i_item.data[bmmd_pkg::PAGE_W-1:0];
                end
            end
            bmmd_pkg::CMD_VSEL: begin
                o_state.video_select = i_item.data;
            end
            bmmd_pkg::CMD_LINE: begin
                if (i_item.line_number == bmmd_pkg::LINE_TOP) begin
                    o_result.vblank_drive = bmmd_pkg::VB_HIGH;
                end else if (i_item.line_number == bmmd_pkg::LINE_VBL) begin
                    o_result.vblank_drive = bmmd_pkg::VB_LOW;
                end
                o_state.in_hblank = 1'b0;
            end
            bmmd_pkg::CMD_HBLANK: begin
                o_state.in_hblank       = 1'b1;
                o_result.busreq_release = 1'b1;
            end
            bmmd_pkg::CMD_IPL: begin
                o_state.boot_mode = 1'b1;
            end
            bmmd_pkg::CMD_SPECIAL: begin
                o_state.boot_mode = 1'b0;
            end
            default: begin
            end
        endcase
    end

endmodule

// File: rtl/bank_mapped_memory_decoder_top.sv
// ----------------------------------------------------------------------------
// Bank-mapped memory decoder, top level
// Decodes CPU accesses into region and offset, tracking boot and video state.
// ----------------------------------------------------------------------------
//  Channel   Direction  Handshake      Beat contents
//  i_in      in         valid/ready    command, address, data, line_number
//  o_out     out        valid/ready    region, phys_offset, flags, vblank_drive
//  i_cfg_*   in         write enable   machine variant (1 bit)
//
// One beat per cycle is accepted while the result register is free; a result is
// offered once its beat has passed the input register and then the result
// register, and is held there until it is taken.
// Kept state is updated as a beat moves from the input to the result register.
// Reset (synchronous, active low) maps the boot ROM and clears video state.
// When the result is stalled, the input register still takes one more beat.
// ----------------------------------------------------------------------------
module bank_mapped_memory_decoder_top (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_cfg_we,
    input  logic               i_cfg_wdata,
    bmmd_in_if.sink            i_in,
    bmmd_out_if.source         o_out
);

    logic              r_variant;
    bmmd_pkg::t_state  r_state;
    bmmd_pkg::t_state  n_state;
    logic              r_in_valid;
    bmmd_pkg::t_item   r_item;
    logic              r_out_valid;
    bmmd_pkg::t_result r_result;
    bmmd_pkg::t_result n_result;
    logic              advance;

    // Stage control: the result register frees when empty or taken.
    assign advance    = r_in_valid && (!r_out_valid || o_out.ready);
    assign i_in.ready = !r_in_valid || advance;

    // Configuration register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_variant <= bmmd_pkg::DEFAULT_VARIANT;
        end else if (i_cfg_we) begin
            r_variant <= i_cfg_wdata;
        end
    end

    // Input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_in.ready) begin
            r_in_valid <= i_in.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in.valid && i_in.ready) begin
            r_item.command     <= i_in.command;
            r_item.address     <= i_in.address;
            r_item.data        <= i_in.data;
            r_item.line_number <= i_in.line_number;
        end
    end

    // Decode logic between the two registers.
    bmmd_decode u_decode (
        .i_variant (r_variant),
        .i_state   (r_state),
        .i_item    (r_item),
        .o_result  (n_result),
        .o_state   (n_state)
    );

    // Kept state and result register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state.boot_mode    <= 1'b1;
            r_state.video_select <= '0;
            r_state.video_page   <= '0;
            r_state.in_hblank    <= 1'b0;
            r_out_valid          <= 1'b0;
        end else begin
            if (advance) begin
                r_state     <= n_state;
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= n_result;
        end
    end

    assign o_out.valid          = r_out_valid;
    assign o_out.region         = r_result.region;
    assign o_out.phys_offset    = r_result.phys_offset;
    assign o_out.wait_state     = r_result.wait_state;
    assign o_out.busreq_assert  = r_result.busreq_assert;
    assign o_out.busreq_release = r_result.busreq_release;
    assign o_out.vblank_drive   = r_result.vblank_drive;

endmodule

// File: rtl/bmmd_checker.sv
// ----------------------------------------------------------------------------
// Decoder port checker
// Assertions on the top level's ports, attached by bind.
// ----------------------------------------------------------------------------
module bmmd_checker (
    input logic                          i_clk,
    input logic                          i_rst_n,
    input logic                          i_out_valid,
    input logic                          i_out_ready,
    input logic [bmmd_pkg::REGION_W-1:0] i_region,
    input logic [bmmd_pkg::ADDR_W-1:0]   i_phys_offset,
    input logic                          i_wait_state,
    input logic                          i_busreq_assert,
    input logic                          i_busreq_release,
    input logic [bmmd_pkg::VB_W-1:0]     i_vblank_drive
);

    // No result is offered in the cycle after reset.
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    // A stalled result beat keeps its payload.
    a_stall_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid && $stable(i_region)
            && $stable(i_phys_offset) && $stable(i_busreq_assert))
        else $error("stalled result changed");

    // A wait is raised only for a boot ROM fetch.
    a_wait_rom: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_wait_state |-> i_region == bmmd_pkg::REG_ROM)
        else $error("wait without boot ROM region");

    // A bus request only comes with a video memory region.
    a_busreq_video: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_busreq_assert |->
            i_region == bmmd_pkg::REG_GVRAM || i_region == bmmd_pkg::REG_TVRAM)
        else $error("bus request outside video memory");

    // Event results carry no access.
    a_event_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_busreq_release || i_vblank_drive != bmmd_pkg::VB_NONE) |->
            i_region == bmmd_pkg::REG_EMPTY && i_phys_offset == '0)
        else $error("event result carries an access");

endmodule

bind bank_mapped_memory_decoder_top bmmd_checker u_bmmd_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_out_valid      (o_out.valid),
    .i_out_ready      (o_out.ready),
    .i_region         (o_out.region),
    .i_phys_offset    (o_out.phys_offset),
    .i_wait_state     (o_out.wait_state),
    .i_busreq_assert  (o_out.busreq_assert),
    .i_busreq_release (o_out.busreq_release),
    .i_vblank_drive   (o_out.vblank_drive)
);

// File: test/bmmd_decode_checker.sv
// ----------------------------------------------------------------------------
// Decoder result checker
// Watches the access and result channels and the variant register port.
// Keeps its own copy of the decoder state, predicts every result beat, and
// compares each one with the oldest prediction still waiting.
// ----------------------------------------------------------------------------
module bmmd_decode_checker
    import bmmd_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_cfg_we,
    input  logic i_cfg_wdata,
    bmmd_in_if   i_acc,
    bmmd_out_if  i_res,
    output int   o_fail_count,
    output int   o_pending
);

    // Predicted machine state and variant register.
    logic    variant;
    t_state  model_state;
    t_result due_results[$];
    int      fail_total;

    // Base map from boot mode, then the video overlay of the current variant.
    function automatic void map_address(input logic [ADDR_W-1:0] addr, input logic is_write,
                                        output t_region rgn, output logic [ADDR_W-1:0] ofs);
        logic [1:0]        pg4;
        logic [ADDR_W-1:0] gbase;
        if (model_state.boot_mode) begin
            if (addr < ROM_END) begin
                if (is_write) begin
                    // Writes into the boot ROM are dropped.
                    rgn = REG_EMPTY;
                    ofs = '0;
                end else begin
                    rgn = REG_ROM;
                    ofs = addr;
                end
            end else if (addr < RAM_HI) begin
                rgn = REG_EMPTY;
                ofs = '0;
            end else begin
                rgn = REG_RAM;
                ofs = addr - RAM_HI;
            end
        end else begin
            rgn = REG_RAM;
            ofs = addr;
        end

        pg4   = model_state.video_page[1:0];
        gbase = model_state.video_page[0] ? PAGE_SIZE : '0;
        if (variant == VARIANT_FOUR_PAGE) begin
            if (model_state.video_select == VSEL_GRAPH && addr >= V0_GVRAM) begin
                // Page zero leaves the graphics window empty.
                if (pg4 != 2'd0) begin
                    rgn = REG_GVRAM;
                    ofs = ADDR_W'(pg4) * PAGE_SIZE + (addr - V0_GVRAM);
                end else begin
                    rgn = REG_EMPTY;
                    ofs = '0;
                end
            end else if (model_state.video_select == VSEL_TEXT
                         && addr >= HI_TVRAM && addr < HI_GVRAM) begin
                rgn = REG_TVRAM;
                ofs = addr - HI_TVRAM;
            end
        end else begin
            if (model_state.video_select == VSEL_GRAPH) begin
                if (addr >= HI_TVRAM && addr < HI_GVRAM) begin
                    rgn = REG_TVRAM;
                    ofs = addr - HI_TVRAM;
                end else if (addr >= HI_GVRAM) begin
                    rgn = REG_GVRAM;
                    ofs = gbase + (addr - HI_GVRAM);
                end
            end else if (model_state.video_select == VSEL_TEXT) begin
                if (addr >= LO_TVRAM && addr < LO_GVRAM) begin
                    rgn = REG_TVRAM;
                    ofs = addr - LO_TVRAM;
                end else if (addr >= LO_GVRAM && addr < RAM_HI) begin
                    rgn = REG_GVRAM;
                    ofs = gbase + (addr - LO_GVRAM);
                end
            end
        end
    endfunction

    // Result of one accepted beat; updates the predicted state as a side effect.
    function automatic t_result decode_beat(input t_item it);
        t_result           res;
        t_region           rgn;
        logic [ADDR_W-1:0] ofs;
        logic [7:0]        port;
        res  = '0;
        port = it.address[7:0];
        case (it.command)
            CMD_READ, CMD_WRITE: begin
                map_address(it.address, it.command == CMD_WRITE, rgn, ofs);
                res.region        = rgn;
                res.phys_offset   = ofs;
                res.busreq_assert = !model_state.in_hblank
                                    && (rgn == REG_GVRAM || rgn == REG_TVRAM);
            end
            CMD_FETCH: begin
                map_address(it.address, 1'b0, rgn, ofs);
                res.region      = rgn;
                res.phys_offset = ofs;
                res.wait_state  = model_state.boot_mode && it.address < ROM_END;
            end
            CMD_IOWR: begin
                if (variant == VARIANT_FOUR_PAGE) begin
                    if (port == PORT_PAGE) model_state.video_page = {1'b0, it.data[1:0]};
                end else if (port >= PORT_LO && port <= PORT_PAGE) begin
                    model_state.video_page = it.data[2:0];
                end
            end
            CMD_VSEL: begin
                model_state.video_select = it.data;
            end
            CMD_LINE: begin
                if (it.line_number == LINE_TOP) res.vblank_drive = VB_HIGH;
                else if (it.line_number == LINE_VBL) res.vblank_drive = VB_LOW;
                model_state.in_hblank = 1'b0;
            end
            CMD_HBLANK: begin
                model_state.in_hblank = 1'b1;
                res.busreq_release    = 1'b1;
            end
            CMD_IPL: begin
                model_state.boot_mode = 1'b1;
            end
            CMD_SPECIAL: begin
                model_state.boot_mode = 1'b0;
            end
            default: begin
                // Undefined commands leave state alone and give an all-zero result.
            end
        endcase
        return res;
    endfunction

    function automatic string describe(input t_result r);
        return $sformatf("region=%0d offset=%h wait=%0b req=%0b rel=%0b vb=%0d",
                         r.region, r.phys_offset, r.wait_state, r.busreq_assert,
                         r.busreq_release, r.vblank_drive);
    endfunction

    // Sample both channels at each edge: results first, then new predictions.
    always @(posedge i_clk) begin
        t_result got;
        t_result want;
        t_item   acc;
        if (!i_rst_n) begin
            variant     = DEFAULT_VARIANT;
            model_state = '0;
            model_state.boot_mode = 1'b1;
            due_results.delete();
            fail_total  = 0;
        end else begin
            if (i_cfg_we) variant = i_cfg_wdata;

            if (i_res.valid && i_res.ready) begin
                got.region         = i_res.region;
                got.phys_offset    = i_res.phys_offset;
                got.wait_state     = i_res.wait_state;
                got.busreq_assert  = i_res.busreq_assert;
                got.busreq_release = i_res.busreq_release;
                got.vblank_drive   = i_res.vblank_drive;
                if (due_results.size() == 0) begin
                    fail_total++;
                    $display("%0t: result beat with nothing expected, actual %s",
                             $time, describe(got));
                end else begin
                    want = due_results.pop_front();
                    if (got.region !== want.region
                        || got.phys_offset !== want.phys_offset
                        || got.wait_state !== want.wait_state
                        || got.busreq_assert !== want.busreq_assert
                        || got.busreq_release !== want.busreq_release
                        || got.vblank_drive !== want.vblank_drive) begin
                        fail_total++;
                        $display("%0t: mismatch, expected %s, actual %s",
                                 $time, describe(want), describe(got));
                    end
                end
            end

            if (i_acc.valid && i_acc.ready) begin
                acc.command     = i_acc.command;
                acc.address     = i_acc.address;
                acc.data        = i_acc.data;
                acc.line_number = i_acc.line_number;
                due_results.push_back(decode_beat(acc));
            end
        end
        o_fail_count <= fail_total;
        o_pending    <= due_results.size();
    end

endmodule

// File: test/tb_bank_mapped_memory_decoder_top.sv
// ----------------------------------------------------------------------------
// Bank-mapped memory decoder testbench
// Drives directed and random bus accesses and events through the decoder in
// both machine variants, with random idling on both channels, a long result
// stall and a full drain. A separate checker predicts and compares results.
// ----------------------------------------------------------------------------
module tb_bank_mapped_memory_decoder_top;
    import bmmd_pkg::*;

    localparam int LONG_HOLD        = 60;
    localparam int TAIL_CYCLES      = 6;
    localparam int RANDOM_PER_PHASE = 430;
    localparam int NUM_PHASES       = 4;

    logic i_clk;
    logic i_rst_n;
    logic i_cfg_we;
    logic i_cfg_wdata;
    int   fail_count;
    int   pending;
    logic sink_stall_on;
    logic src_idle_on;
    int   hold_requests;

    bmmd_in_if  acc_ch ();
    bmmd_out_if res_ch ();

    bank_mapped_memory_decoder_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_wdata (i_cfg_wdata),
        .i_in        (acc_ch),
        .o_out       (res_ch)
    );

    bmmd_decode_checker decode_check (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_acc        (acc_ch),
        .i_res        (res_ch),
        .o_fail_count (fail_count),
        .o_pending    (pending)
    );

    initial i_clk = 1'b0;
    always #5 i_clk = ~i_clk;

    // Hard limit on the run.
    initial begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

    // Result side: random stall bursts, plus long holds on request.
    initial begin
        int holds_done;
        holds_done = 0;
        res_ch.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (holds_done != hold_requests) begin
                res_ch.ready <= 1'b0;
                repeat (LONG_HOLD) @(posedge i_clk);
                holds_done++;
            end else if (sink_stall_on && $urandom_range(0, 3) == 0) begin
                res_ch.ready <= 1'b0;
                repeat ($urandom_range(1, 7)) @(posedge i_clk);
            end else begin
                res_ch.ready <= 1'b1;
                @(posedge i_clk);
            end
        end
    end

    function automatic t_item beat(input logic [CMD_W-1:0] cmd, input logic [ADDR_W-1:0] addr,
                                   input logic [DATA_W-1:0] dat, input logic [LINE_W-1:0] ln);
        t_item it;
        it.command     = cmd;
        it.address     = addr;
        it.data        = dat;
        it.line_number = ln;
        return it;
    endfunction

    // Addresses cluster around the map boundaries, with some fully random.
    function automatic logic [ADDR_W-1:0] pick_address();
        logic [ADDR_W-1:0] base;
        if ($urandom_range(0, 3) == 0) return ADDR_W'($urandom);
        case ($urandom_range(0, 8))
            0:       base = '0;
            1:       base = ROM_END;
            2:       base = LO_TVRAM;
            3:       base = LO_GVRAM;
            4:       base = RAM_HI;
            5:       base = V0_GVRAM;
            6:       base = HI_TVRAM;
            7:       base = HI_GVRAM;
            default: base = '1;
        endcase
        return base + ADDR_W'($urandom_range(0, 15)) - ADDR_W'(8);
    endfunction

    // Mostly memory accesses, with enough events to move all the kept state.
    function automatic t_item random_beat();
        t_item it;
        int    pick;
        pick           = $urandom_range(0, 99);
        it.address     = pick_address();
        it.data        = DATA_W'($urandom);
        it.line_number = LINE_W'($urandom);
        if (pick < 22)      it.command = CMD_READ;
        else if (pick < 40) it.command = CMD_WRITE;
        else if (pick < 52) it.command = CMD_FETCH;
        else if (pick < 64) it.command = CMD_IOWR;
        else if (pick < 74) it.command = CMD_VSEL;
        else if (pick < 82) it.command = CMD_LINE;
        else if (pick < 90) it.command = CMD_HBLANK;
        else if (pick < 94) it.command = CMD_IPL;
        else if (pick < 98) it.command = CMD_SPECIAL;
        else                it.command = CMD_W'($urandom_range(9, 15));
        case (it.command)
            CMD_IOWR: begin
                if ($urandom_range(0, 1) == 1)
                    it.address[7:0] = PORT_LO + 8'($urandom_range(0, 3));
            end
            CMD_VSEL: begin
                case ($urandom_range(0, 4))
                    0, 1:    it.data = VSEL_GRAPH;
                    2, 3:    it.data = VSEL_TEXT;
                    default: ;
                endcase
            end
            CMD_LINE: begin
                case ($urandom_range(0, 3))
                    0:       it.line_number = LINE_TOP;
                    1:       it.line_number = LINE_VBL;
                    default: ;
                endcase
            end
            default: ;
        endcase
        return it;
    endfunction

    // Offer one beat and hold it until the decoder takes it; valid then stays high unless a random idle gap follows.
    task automatic send_beat(input t_item it);
        acc_ch.valid       <= 1'b1;
        acc_ch.command     <= it.command;
        acc_ch.address     <= it.address;
        acc_ch.data        <= it.data;
        acc_ch.line_number <= it.line_number;
        do @(posedge i_clk); while (!acc_ch.ready);
        if (src_idle_on && $urandom_range(0, 3) == 0) begin
            acc_ch.valid   <= 1'b0;
            acc_ch.command <= CMD_W'($urandom);
            acc_ch.address <= ADDR_W'($urandom);
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
    endtask

    // Stop offering beats until every expected result has come back.
    task automatic wait_for_results();
        acc_ch.valid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (TAIL_CYCLES) @(posedge i_clk);
    endtask

    task automatic set_variant(input logic v);
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
    endtask

    // Main stimulus and verdict.
    initial begin
        int phase;
        int n;
        i_rst_n            <= 1'b0;
        i_cfg_we           <= 1'b0;
        i_cfg_wdata        <= 1'b0;
        acc_ch.valid       <= 1'b0;
        acc_ch.command     <= '0;
        acc_ch.address     <= '0;
        acc_ch.data        <= '0;
        acc_ch.line_number <= '0;
        sink_stall_on = 1'b1;
        src_idle_on   = 1'b1;
        hold_requests = 0;
        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);
        set_variant(VARIANT_FOUR_PAGE);

        // Boot mode map, ROM wait, dropped ROM write, empty window edges.
        send_beat(beat(CMD_FETCH, 16'h0000, 8'h00, 9'd0));
        send_beat(beat(CMD_FETCH, ROM_END - 16'd1, 8'h00, 9'd0));
        send_beat(beat(CMD_READ, ROM_END - 16'd1, 8'h00, 9'd0));
        send_beat(beat(CMD_WRITE, 16'h0000, 8'hff, 9'd0));
        send_beat(beat(CMD_READ, ROM_END, 8'h00, 9'd0));
        send_beat(beat(CMD_READ, RAM_HI - 16'd1, 8'h00, 9'd0));
        send_beat(beat(CMD_READ, RAM_HI, 8'h00, 9'd0));
        send_beat(beat(CMD_WRITE, 16'hffff, 8'h00, 9'd0));
        // Graphics page three, inside and outside hblank, and a VRAM fetch.
        send_beat(beat(CMD_IOWR, {8'h00, PORT_PAGE}, 8'hff, 9'd0));
        send_beat(beat(CMD_VSEL, 16'h0000, VSEL_GRAPH, 9'd0));
        send_beat(beat(CMD_READ, V0_GVRAM, 8'h00, 9'd0));
        send_beat(beat(CMD_FETCH, 16'hffff, 8'h00, 9'd0));
        send_beat(beat(CMD_HBLANK, 16'h0000, 8'h00, 9'd0));
        send_beat(beat(CMD_WRITE, 16'hffff, 8'h00, 9'd0));
        // Vertical blank lines and the largest line number.
        send_beat(beat(CMD_LINE, 16'h0000, 8'h00, LINE_TOP));
        send_beat(beat(CMD_LINE, 16'h0000, 8'h00, LINE_VBL));
        send_beat(beat(CMD_LINE, 16'hffff, 8'hff, 9'd511));
        // Normal mode, page zero leaves the graphics window empty, text VRAM.
        send_beat(beat(CMD_SPECIAL, 16'h0000, 8'h00, 9'd0));
        send_beat(beat(CMD_READ, 16'h0000, 8'h00, 9'd0));
        send_beat(beat(CMD_IOWR, {8'hff, PORT_PAGE}, 8'h00, 9'd0));
        send_beat(beat(CMD_READ, V0_GVRAM, 8'h00, 9'd0));
        send_beat(beat(CMD_VSEL, 16'h0000, VSEL_TEXT, 9'd0));
        send_beat(beat(CMD_READ, HI_TVRAM, 8'h00, 9'd0));
        send_beat(beat(CMD_WRITE, HI_GVRAM - 16'd1, 8'h00, 9'd0));
        send_beat(beat(CMD_IPL, 16'h0000, 8'h00, 9'd0));
        send_beat(beat(CMD_W'(15), 16'hffff, 8'hff, 9'd511));
        wait_for_results();

        // Random phases alternate the variant; the last one runs without idling.
        for (phase = 0; phase < NUM_PHASES; phase++) begin
            set_variant(phase % 2 == 0 ? VARIANT_TWO_PAGE : VARIANT_FOUR_PAGE);
            for (n = 0; n < RANDOM_PER_PHASE; n++) begin
                if (phase == NUM_PHASES - 1) begin
                    src_idle_on   = 1'b0;
                    sink_stall_on = 1'b0;
                end else if (n % 50 == 0) begin
                    src_idle_on   = $urandom_range(0, 2) != 0;
                    sink_stall_on = $urandom_range(0, 2) != 0;
                end
                if (phase == 1 && n == 100) hold_requests++;
                if (phase == 2 && n == 200) wait_for_results();
                send_beat(random_beat());
            end
            wait_for_results();
        end

        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule
